### sv/bsld_pkg.sv
// Shared types, codes and constants for the buckle sensor level debounce block.
package bsld_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int RUN_BITS        = 8;

  // Band limits on the sample scaled by four
  localparam int LIM_OVER        = 20000;
  localparam int LIM_UNBUCKLED   = 12000;
  localparam int LIM_BUCKLED_LO  = 2000;
  localparam int LIM_BUCKLED_HI  = 10000;
  localparam int SCALE_SHIFT     = 2;

  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

  typedef enum logic [1:0] {
    ST_FASTENED   = 2'd0,
    ST_UNFASTENED = 2'd1,
    ST_UNKNOWN    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BAND_BUCKLED   = 2'd0,
    BAND_UNBUCKLED = 2'd1,
    BAND_UNDET     = 2'd2,
    BAND_OVER      = 2'd3
  } band_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BUCKLED_COUNT      = 2'd0,
    REG_UNBUCKLED_COUNT    = 2'd1,
    REG_UNDETERMINED_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RUN_BITS-1:0] buckled;
    logic [RUN_BITS-1:0] unbuckled;
    logic [RUN_BITS-1:0] undetermined;
  } counts_t;

endpackage

### sv/bsld_classify.sv
// Scales one sample by four and sorts it into its band.
module bsld_classify import bsld_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] sample,
  output band_t                  band
);

  // wide enough for the scaled sample and for the largest limit
  localparam int VW = (SAMPLE_BITS + SCALE_SHIFT > 15) ? SAMPLE_BITS + SCALE_SHIFT : 15;

  logic [VW-1:0] v;

  assign v = VW'({sample, {SCALE_SHIFT{1'b0}}});

  always_comb begin
    if (v > VW'(LIM_OVER)) begin
      band = BAND_OVER;
    end else if (v >= VW'(LIM_UNBUCKLED)) begin
      band = BAND_UNBUCKLED;
    end else if (v >= VW'(LIM_BUCKLED_LO) && v <= VW'(LIM_BUCKLED_HI)) begin
      band = BAND_BUCKLED;
    end else begin
      band = BAND_UNDET;
    end
  end

endmodule

### sv/bsld_tracker.sv
// Run counters and the fastened / unfastened / unknown status machine.
module bsld_tracker import bsld_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  band_t   band,
  input  counts_t counts,
  output status_t status_next
);

  status_t             status;
  logic [RUN_BITS-1:0] buckled_run, unbuckled_run, undetermined_run;
  logic [RUN_BITS-1:0] buckled_upd, unbuckled_upd, undetermined_upd;
  logic [RUN_BITS-1:0] buckled_run_next, unbuckled_run_next, undetermined_run_next;
  logic                moved;

  function automatic logic [RUN_BITS-1:0] run_inc(input logic [RUN_BITS-1:0] r);
    return (r == RUN_MAX) ? RUN_MAX : r + RUN_BITS'(1);
  endfunction

  // band update of the run counters; over range holds them all
  always_comb begin
    buckled_upd      = buckled_run;
    unbuckled_upd    = unbuckled_run;
    undetermined_upd = undetermined_run;
    case (band)
      BAND_BUCKLED: begin
        buckled_upd      = run_inc(buckled_run);
        unbuckled_upd    = '0;
        undetermined_upd = '0;
      end
      BAND_UNBUCKLED: begin
        buckled_upd      = '0;
        unbuckled_upd    = run_inc(unbuckled_run);
        undetermined_upd = '0;
      end
      BAND_UNDET: begin
        buckled_upd      = '0;
        unbuckled_upd    = '0;
        undetermined_upd = run_inc(undetermined_run);
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    status_next = status;
    moved       = 1'b0;
    case (status)
      ST_FASTENED: begin
        if (unbuckled_upd == counts.unbuckled) begin
          status_next = ST_UNFASTENED;
          moved       = 1'b1;
        end else if (undetermined_upd == counts.undetermined) begin
          status_next = ST_UNKNOWN;
          moved       = 1'b1;
        end
      end
      ST_UNFASTENED: begin
        if (buckled_upd == counts.buckled) begin
          status_next = ST_FASTENED;
          moved       = 1'b1;
        end else if (undetermined_upd == counts.undetermined) begin
          status_next = ST_UNKNOWN;
          moved       = 1'b1;
        end
      end
      ST_UNKNOWN: begin
        if (buckled_upd == counts.buckled) begin
          status_next = ST_FASTENED;
          moved       = 1'b1;
        end else if (unbuckled_upd == counts.unbuckled) begin
          status_next = ST_UNFASTENED;
          moved       = 1'b1;
        end
      end
      default: begin
        // stray code: go unknown, runs not cleared
        status_next = ST_UNKNOWN;
      end
    endcase
  end

  // counter outputs: every move clears all runs
  always_comb begin
    buckled_run_next      = moved ? '0 : buckled_upd;
    unbuckled_run_next    = moved ? '0 : unbuckled_upd;
    undetermined_run_next = moved ? '0 : undetermined_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status           <= ST_FASTENED;
      buckled_run      <= '0;
      unbuckled_run    <= '0;
      undetermined_run <= '0;
    end else if (fire) begin
      status           <= status_next;
      buckled_run      <= buckled_run_next;
      unbuckled_run    <= unbuckled_run_next;
      undetermined_run <= undetermined_run_next;
    end
  end

endmodule

### sv/buckle_sensor_level_debounce.sv
// Top level of the buckle sensor level debounce block.
//
// Each input word carries one raw ADC sample of the buckle pad. The sample is
// scaled by four and sorted into a band (buckled, unbuckled, undetermined or
// over range); the band's run counter advances while the others clear, over
// range holding all runs, and a fastened / unfastened / unknown status machine
// moves once a run reaches its configured count. Every input word gives
// exactly one output word holding the band of that sample and the status after it.
// Channels: in_valid/in_stall with sample; out_valid/out_stall with
// belt_status and sample_band. A word moves when valid is high and stall low.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, an index past the last register is ignored.
// Words pass through the input register, then the result register; one word
// per cycle is taken and delivered while out_stall is low, the status and run
// counters being updated as each word passes between the two registers.
// Reset: counts go to 3, status to fastened, all runs to zero, both
// registers empty. When out_stall is held the result register keeps its word,
// the input register fills behind it and in_stall then rises.
module buckle_sensor_level_debounce import bsld_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                belt_status,
  output logic [1:0]                sample_band,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [RUN_BITS-1:0]       cfg_data
);

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   s1_fire;
  logic                   out_free;
  band_t                  band;
  status_t                status_next;
  counts_t                counts;
  status_t                res_status;
  band_t                  res_band;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts.buckled      <= RUN_BITS'(3);
      counts.unbuckled    <= RUN_BITS'(3);
      counts.undetermined <= RUN_BITS'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BUCKLED_COUNT:      counts.buckled      <= cfg_data;
        REG_UNBUCKLED_COUNT:    counts.unbuckled    <= cfg_data;
        REG_UNDETERMINED_COUNT: counts.undetermined <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= sample;
    end
  end

  bsld_classify #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_classify (
    .sample(s1_sample),
    .band  (band)
  );

  bsld_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .band       (band),
    .counts     (counts),
    .status_next(status_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_status <= status_next;
      res_band   <= band;
    end
  end

  assign belt_status = res_status;
  assign sample_band = res_band;

`ifndef NO_ASSERTIONS
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (belt_status == ST_FASTENED || belt_status == ST_UNFASTENED ||
                   belt_status == ST_UNKNOWN))
    else $error("unreachable status code on output");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("word left the input register but no result appeared");
`endif

endmodule

### sim/buckle_sensor_level_debounce_tb.sv
// Self-checking testbench for buckle_sensor_level_debounce: status and band predicted per sample.
`timescale 1ns / 1ps
module buckle_sensor_level_debounce_tb;
  import bsld_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX  = (1 << SB) - 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 10;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;  // decodes to no register

  // band edges in raw sample units (limits are multiples of four)
  localparam int BUCKLED_LO   = LIM_BUCKLED_LO >> SCALE_SHIFT;
  localparam int BUCKLED_HI   = LIM_BUCKLED_HI >> SCALE_SHIFT;
  localparam int UNBUCKLED_LO = LIM_UNBUCKLED >> SCALE_SHIFT;
  localparam int OVER_EDGE    = LIM_OVER >> SCALE_SHIFT;
  localparam int UNBUCKLED_HI = (OVER_EDGE < SAMPLE_MAX) ? OVER_EDGE : SAMPLE_MAX;
  localparam bit OVER_REACHABLE = SAMPLE_MAX > OVER_EDGE;

  typedef struct {
    status_t status;
    band_t   band;
  } belt_word_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [SB-1:0]             sample    = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                belt_status;
  logic [1:0]                sample_band;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [RUN_BITS-1:0]       cfg_data  = '0;

  buckle_sensor_level_debounce #(.SAMPLE_BITS(SB)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .belt_status(belt_status), .sample_band(sample_band),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // debounce state mirror
  status_t             belt_now = ST_FASTENED;
  logic [RUN_BITS-1:0] run_buckled = '0, run_unbuckled = '0, run_undet = '0;
  logic [RUN_BITS-1:0] need_buckled = 8'd3, need_unbuckled = 8'd3, need_undet = 8'd3;

  logic [SB-1:0] sample_q [$];
  belt_word_t    belt_q [$];

  bit in_took = 1'b0, cfg_took = 1'b0, idle_on = 1'b0;
  int quiet_cycles = 0, fail_count = 0;
  int n_samples = 0, n_results = 0, n_moves = 0, n_writes = 0;
  int gap_left = 0, burst_left = 0, stall_left = 0;
  logic [15:0] stall_pat = '0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d (word %0d)",
             $realtime, what, got, want, n_results);
    fail_count++;
  endtask

  function automatic logic [RUN_BITS-1:0] bump(input logic [RUN_BITS-1:0] r);
    return (r == RUN_MAX) ? r : r + RUN_BITS'(1);
  endfunction

  function automatic void move_belt(input status_t s);
    run_buckled   = '0;
    run_unbuckled = '0;
    run_undet     = '0;
    belt_now      = s;
    n_moves++;
  endfunction

  function automatic belt_word_t debounce_step(input logic [SB-1:0] s);
    int unsigned scaled;
    band_t       b;
    belt_word_t  w;
    scaled = int'(s) << SCALE_SHIFT;
    if (scaled > LIM_OVER) b = BAND_OVER;
    else if (scaled >= LIM_UNBUCKLED) b = BAND_UNBUCKLED;
    else if (scaled >= LIM_BUCKLED_LO && scaled <= LIM_BUCKLED_HI) b = BAND_BUCKLED;
    else b = BAND_UNDET;
    case (b)
      BAND_UNBUCKLED: begin
        run_unbuckled = bump(run_unbuckled);
        run_buckled   = '0;
        run_undet     = '0;
      end
      BAND_BUCKLED: begin
        run_buckled   = bump(run_buckled);
        run_unbuckled = '0;
        run_undet     = '0;
      end
      BAND_UNDET: begin
        run_undet     = bump(run_undet);
        run_buckled   = '0;
        run_unbuckled = '0;
      end
      default: ;  // over range holds every run
    endcase
    case (belt_now)
      ST_FASTENED: begin
        if (run_unbuckled == need_unbuckled) move_belt(ST_UNFASTENED);
        else if (run_undet == need_undet) move_belt(ST_UNKNOWN);
      end
      ST_UNFASTENED: begin
        if (run_buckled == need_buckled) move_belt(ST_FASTENED);
        else if (run_undet == need_undet) move_belt(ST_UNKNOWN);
      end
      ST_UNKNOWN: begin
        if (run_buckled == need_buckled) move_belt(ST_FASTENED);
        else if (run_unbuckled == need_unbuckled) move_belt(ST_UNFASTENED);
      end
      default: belt_now = ST_UNKNOWN;
    endcase
    w.status = belt_now;
    w.band   = b;
    return w;
  endfunction

  // sampled at the rising edge: config, input and output handshakes
  always @(posedge clk) begin
    belt_word_t want;
    if (!rst) begin
      in_took  <= in_valid && !in_stall;
      cfg_took <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          REG_BUCKLED_COUNT:      need_buckled   = cfg_data;
          REG_UNBUCKLED_COUNT:    need_unbuckled = cfg_data;
          REG_UNDETERMINED_COUNT: need_undet     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        n_samples++;
        belt_q.push_back(debounce_step(sample));
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (belt_q.size() == 0) begin
          report_mismatch("output word with nothing pending", belt_status, -1);
        end else begin
          want = belt_q.pop_front();
          if (belt_status !== want.status) report_mismatch("belt_status", belt_status, want.status);
          if (sample_band !== want.band) report_mismatch("sample_band", sample_band, want.band);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sender in bursts, receiver on a shifting stall pattern; both change on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_took) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (sample_q.size() != 0) begin
          in_valid <= 1'b1;
          sample   <= sample_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = idle_on ? $urandom_range(1, 12) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left == 0) begin
        stall_left = 16;
        case ($urandom_range(0, 7))
          0, 1, 2: stall_pat = '0;
          3, 4:    stall_pat = 16'($urandom & $urandom);
          5:       stall_pat = 16'($urandom);
          6:       stall_pat = 16'($urandom | $urandom);
          default: stall_pat = '1;
        endcase
      end
      out_stall <= idle_on && stall_pat[0];
      stall_pat = stall_pat >> 1;
      stall_left--;
    end
  end

  function automatic logic [SB-1:0] pick_sample(input band_t b);
    int lo, hi;
    case (b)
      BAND_BUCKLED:   begin lo = BUCKLED_LO;       hi = BUCKLED_HI;   end
      BAND_UNBUCKLED: begin lo = UNBUCKLED_LO;     hi = UNBUCKLED_HI; end
      BAND_OVER:      begin lo = UNBUCKLED_HI + 1; hi = SAMPLE_MAX;   end
      default: begin
        if ($urandom_range(0, 1)) begin
          lo = 0;
          hi = BUCKLED_LO - 1;
        end else begin
          lo = BUCKLED_HI + 1;
          hi = UNBUCKLED_LO - 1;
        end
      end
    endcase
    case ($urandom_range(0, 7))
      0:       return SB'(lo);
      1:       return SB'(hi);
      default: return SB'($urandom_range(lo, hi));
    endcase
  endfunction

  // mostly runs of one band so the status machine gets to move; some raw noise
  task automatic queue_runs(input int n, input int max_run);
    int    queued, len;
    band_t b;
    queued = 0;
    while (queued < n) begin
      if ($urandom_range(0, 9) == 0) begin
        sample_q.push_back(SB'($urandom_range(0, SAMPLE_MAX)));
        queued++;
      end else begin
        b   = band_t'($urandom_range(0, OVER_REACHABLE ? 3 : 2));
        len = $urandom_range(1, max_run);
        repeat (len) sample_q.push_back(pick_sample(b));
        queued += len;
      end
    end
  endtask

  // checked at the rising edge, where the sender's signals and queue are settled
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid || belt_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [RUN_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [RUN_BITS-1:0] bc, uc, dc, input int n, max_run,
                           input bit idle, input bit pause);
    wait_drained();
    write_reg(REG_BUCKLED_COUNT, bc);
    write_reg(REG_UNBUCKLED_COUNT, uc);
    write_reg(REG_UNDETERMINED_COUNT, dc);
    idle_on = idle;
    if (pause) begin
      queue_runs(n / 2, max_run);
      wait_drained();  // let the pipe run dry mid phase
      queue_runs(n - n / 2, max_run);
    end else begin
      queue_runs(n, max_run);
    end
  endtask

  initial begin
    int unsigned directed [];
    // walks the transitions into and out of unknown at the reset counts, plus band edges and bit extremes
    directed = '{
      0, BUCKLED_LO - 1, BUCKLED_HI + 1,             // fastened -> unknown
      UNBUCKLED_LO, SAMPLE_MAX, 3500,                // unknown -> unfastened
      BUCKLED_LO, BUCKLED_HI, 2730,                  // broken buckled run
      UNBUCKLED_LO, BUCKLED_LO, UNBUCKLED_LO + 1,    // broken unbuckled run
      SAMPLE_MAX, UNBUCKLED_LO,                      // unbuckled run, no move while unfastened
      UNBUCKLED_LO - 1, BUCKLED_HI + 1, 0,           // unfastened -> unknown
      1365, BUCKLED_LO + 1, BUCKLED_HI               // unknown -> fastened
    };
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;
    foreach (directed[i]) sample_q.push_back(SB'(directed[i]));

    run_phase(8'd1, 8'd1, 8'd1, 200, 3, 1'b0, 1'b0);
    run_phase(8'd255, 8'd255, 8'd255, 500, 300, 1'b1, 1'b0);
    run_phase(8'd0, 8'd0, 8'd0, 150, 4, 1'b1, 1'b0);
    wait_drained();
    write_reg(REG_SPARE, RUN_BITS'($urandom));
    run_phase(RUN_BITS'($urandom_range(1, 12)), RUN_BITS'($urandom_range(1, 12)),
              RUN_BITS'($urandom_range(1, 12)), 220, 16, 1'b1, 1'b1);
    run_phase(RUN_BITS'($urandom_range(1, 12)), RUN_BITS'($urandom_range(1, 12)),
              RUN_BITS'($urandom_range(1, 12)), 220, 16, 1'b0, 1'b0);
    run_phase(RUN_BITS'($urandom_range(1, 12)), RUN_BITS'($urandom_range(1, 12)),
              RUN_BITS'($urandom_range(1, 12)), 220, 16, 1'b1, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (belt_q.size() != 0) report_mismatch("words still pending at end", 0, belt_q.size());
    $display("Checked %0d output words for %0d samples under %0d register writes;",
             n_results, n_samples, n_writes);
    $display("the belt status machine moved %0d times across seven count settings.", n_moves);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog: too long with no word moving on any channel
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with no handshake", QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
sv/bsld_pkg.sv
sv/bsld_classify.sv
sv/bsld_tracker.sv
sv/buckle_sensor_level_debounce.sv
sim/buckle_sensor_level_debounce_tb.sv
